### rtl/qcis_pkg.sv
// ----------------------------------------------------------------------------
// qcis_pkg
// Shared types, register codes and walk functions for the codeword
// interleave sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package qcis_pkg;

    localparam int MAX_BLOCKS_DEF = 128;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;
    localparam int BIT_LEN_W      = 20;

    localparam logic [6:0] G1_BLOCKS_RST = 7'd1;
    localparam logic [7:0] G1_LENGTH_RST = 8'd19;
    localparam logic [6:0] G2_BLOCKS_RST = 7'd0;
    localparam logic [7:0] G2_LENGTH_RST = 8'd0;
    localparam logic [7:0] EC_BLOCK_RST  = 8'd7;
    localparam logic [2:0] REMAINDER_RST = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_G1_BLOCKS = 3'd0,
        REG_G1_LENGTH = 3'd1,
        REG_G2_BLOCKS = 3'd2,
        REG_G2_LENGTH = 3'd3,
        REG_EC_BLOCK  = 3'd4,
        REG_REMAINDER = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_DATA = 2'd1,
        PH_EC   = 2'd2,
        PH_PAD  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_EC   = 2'd1,
        KIND_PAD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [6:0] g1_blocks;
        logic [7:0] g1_length;
        logic [6:0] g2_blocks;
        logic [7:0] g2_length;
        logic [7:0] ec_per_block;
        logic [2:0] remainder_bits;
    } cfg_t;

    typedef struct packed {
        logic [7:0] g1;
        logic [7:0] g2;
        logic [7:0] total;
        logic [7:0] maxlen;
    } geom_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] column;
        logic [7:0] block;
    } walk_t;

    typedef struct packed {
        logic  valid;
        walk_t walk;
    } stage_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] block;
    } hit_t;

    function automatic geom_t geometry(cfg_t cfg, logic [8:0] maxb);
        geom_t      g;
        logic [8:0] room;
        g.g1 = ({2'b00, cfg.g1_blocks} > maxb) ? maxb[7:0] : {1'b0, cfg.g1_blocks};
        room = maxb - {1'b0, g.g1};
        g.g2 = ({2'b00, cfg.g2_blocks} > room) ? room[7:0] : {1'b0, cfg.g2_blocks};
        g.total = g.g1 + g.g2;
        g.maxlen = '0;
        if (g.g1 != '0) begin
            g.maxlen = cfg.g1_length;
        end
        if (g.g2 != '0 && cfg.g2_length > g.maxlen) begin
            g.maxlen = cfg.g2_length;
        end
        return g;
    endfunction

    // first non-exhausted block at or after blk in column col
    function automatic hit_t first_in_col(cfg_t cfg, geom_t g, logic [8:0] col,
                                          logic [8:0] blk);
        hit_t       h;
        logic [8:0] start;
        start = (blk < {1'b0, g.g1}) ? {1'b0, g.g1} : blk;
        h.hit   = 1'b0;
        h.block = '0;
        if (blk < {1'b0, g.g1} && col < {1'b0, cfg.g1_length}) begin
            h.hit   = 1'b1;
            h.block = blk[7:0];
        end else if (col < {1'b0, cfg.g2_length} && start < {1'b0, g.total}) begin
            h.hit   = 1'b1;
            h.block = start[7:0];
        end
        return h;
    endfunction

    function automatic walk_t settle_ec(cfg_t cfg, geom_t g, logic [8:0] col,
                                        logic [8:0] blk);
        walk_t      w;
        phase_t     tail;
        logic [8:0] col_inc;
        tail    = (cfg.remainder_bits != '0) ? PH_PAD : PH_DONE;
        col_inc = col + 9'd1;
        if (col >= {1'b0, cfg.ec_per_block} || g.total == '0) begin
            w = '{phase: tail, column: 8'd0, block: 8'd0};
        end else if (blk >= {1'b0, g.total}) begin
            if (col_inc >= {1'b0, cfg.ec_per_block}) begin
                w = '{phase: tail, column: 8'd0, block: 8'd0};
            end else begin
                w = '{phase: PH_EC, column: col_inc[7:0], block: 8'd0};
            end
        end else begin
            w = '{phase: PH_EC, column: col[7:0], block: blk[7:0]};
        end
        return w;
    endfunction

    function automatic walk_t settle_data(cfg_t cfg, geom_t g, logic [8:0] col,
                                          logic [8:0] blk);
        walk_t      w;
        hit_t       h0;
        hit_t       h1;
        logic [8:0] col_inc;
        col_inc = col + 9'd1;
        h0 = first_in_col(cfg, g, col, blk);
        h1 = first_in_col(cfg, g, col_inc, 9'd0);
        if (col >= {1'b0, g.maxlen}) begin
            w = settle_ec(cfg, g, 9'd0, 9'd0);
        end else if (h0.hit) begin
            w = '{phase: PH_DATA, column: col[7:0], block: h0.block};
        end else if (col_inc >= {1'b0, g.maxlen}) begin
            w = settle_ec(cfg, g, 9'd0, 9'd0);
        end else begin
            w = '{phase: PH_DATA, column: col_inc[7:0], block: h1.block};
        end
        return w;
    endfunction

    function automatic walk_t advance(cfg_t cfg, geom_t g, walk_t cur);
        walk_t      w;
        logic [8:0] blk_inc;
        blk_inc = {1'b0, cur.block} + 9'd1;
        unique case (cur.phase)
            PH_DATA: begin
                w = settle_data(cfg, g, {1'b0, cur.column}, blk_inc);
            end
            PH_EC: begin
                w = settle_ec(cfg, g, {1'b0, cur.column}, blk_inc);
            end
            PH_PAD, PH_DONE: begin
                w = '{phase: PH_DONE, column: 8'd0, block: 8'd0};
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/qcis_cfg.sv
// ----------------------------------------------------------------------------
// qcis_cfg
// Configuration register file: group sizes, ec count and remainder bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qcis_cfg
    import qcis_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.g1_blocks      <= G1_BLOCKS_RST;
            cfg_reg.g1_length      <= G1_LENGTH_RST;
            cfg_reg.g2_blocks      <= G2_BLOCKS_RST;
            cfg_reg.g2_length      <= G2_LENGTH_RST;
            cfg_reg.ec_per_block   <= EC_BLOCK_RST;
            cfg_reg.remainder_bits <= REMAINDER_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_G1_BLOCKS: cfg_reg.g1_blocks      <= cfg_data[6:0];
                REG_G1_LENGTH: cfg_reg.g1_length      <= cfg_data;
                REG_G2_BLOCKS: cfg_reg.g2_blocks      <= cfg_data[6:0];
                REG_G2_LENGTH: cfg_reg.g2_length      <= cfg_data;
                REG_EC_BLOCK:  cfg_reg.ec_per_block   <= cfg_data;
                REG_REMAINDER: cfg_reg.remainder_bits <= cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/qcis_step.sv
// ----------------------------------------------------------------------------
// qcis_step
// Walk state: takes an item and moves to the next codeword position.
// ----------------------------------------------------------------------------
`default_nettype none

module qcis_step
    import qcis_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_restart,
    input  wire cfg_t cfg,
    input  wire logic take,
    output stage_t    pos
);

    localparam logic [8:0] MAXB = 9'(MAX_BLOCKS);

    walk_t walk_reg;
    walk_t walk_next;
    logic  p_valid_reg;
    geom_t geom;

    assign geom    = geometry(cfg, MAXB);
    assign s_ready = !p_valid_reg || take;
    assign pos     = '{valid: p_valid_reg, walk: walk_reg};

    always_comb begin
        if (s_restart) begin
            walk_next = settle_data(cfg, geom, 9'd0, 9'd0);
        end else if (walk_reg.phase != PH_DONE) begin
            walk_next = advance(cfg, geom, walk_reg);
        end else begin
            walk_next = walk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg    <= '{phase: PH_DONE, column: 8'd0, block: 8'd0};
            p_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                walk_reg <= walk_next;
            end
            if (s_ready) begin
                p_valid_reg <= s_valid;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/qcis_emit.sv
// ----------------------------------------------------------------------------
// qcis_emit
// Result stage: source address, last flag and bit length for a position.
// ----------------------------------------------------------------------------
`default_nettype none

module qcis_emit
    import qcis_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire stage_t               pos,
    output logic                      take,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_valid_res,
    output logic [1:0]                m_kind,
    output logic [7:0]                m_block_index,
    output logic [7:0]                m_byte_offset,
    output logic [ADDR_BITS-1:0]      m_source_address,
    output logic                      m_last,
    output logic [BIT_LEN_W-1:0]      m_bit_length
);

    localparam logic [8:0] MAXB   = 9'(MAX_BLOCKS);
    localparam int         ADDR_W = (ADDR_BITS > 16) ? ADDR_BITS : 16;

    geom_t               geom;
    walk_t               nxt;
    logic [7:0]          blk;
    logic [7:0]          col;
    logic [7:0]          blk_g2;
    logic [15:0]         mul_l1;
    logic [15:0]         mul_g1;
    logic [15:0]         mul_l2;
    logic [15:0]         mul_ec;
    logic [15:0]         data_base;
    logic [15:0]         base;
    logic [15:0]         addr16;
    logic [ADDR_W-1:0]   addr_wide;
    logic [17:0]         bytes;
    logic [20:0]         bits_full;

    logic                valid_res_c;
    kind_t               kind_c;
    logic [7:0]          block_c;
    logic [7:0]          offset_c;
    logic [ADDR_BITS-1:0] addr_c;
    logic                last_c;
    logic [BIT_LEN_W-1:0] bit_len_c;

    logic                m_valid_reg;
    logic                m_valid_res_reg;
    kind_t               m_kind_reg;
    logic [7:0]          m_block_index_reg;
    logic [7:0]          m_byte_offset_reg;
    logic [ADDR_BITS-1:0] m_source_address_reg;
    logic                m_last_reg;
    logic [BIT_LEN_W-1:0] m_bit_length_reg;

    assign geom   = geometry(cfg, MAXB);
    assign nxt    = advance(cfg, geom, pos.walk);
    assign blk    = pos.walk.block;
    assign col    = pos.walk.column;
    assign blk_g2 = blk - geom.g1;

    assign mul_l1 = 16'(blk) * 16'(cfg.g1_length);
    assign mul_g1 = 16'(geom.g1) * 16'(cfg.g1_length);
    assign mul_l2 = 16'(blk_g2) * 16'(cfg.g2_length);
    assign mul_ec = 16'(blk) * 16'(cfg.ec_per_block);

    assign data_base = (blk < geom.g1) ? mul_l1 : (mul_g1 + mul_l2);
    assign base      = (pos.walk.phase == PH_EC) ? mul_ec : data_base;
    assign addr16    = base + 16'(col);
    assign addr_wide = ADDR_W'(addr16);

    assign bytes = 18'(mul_g1)
                 + 18'(16'(geom.g2) * 16'(cfg.g2_length))
                 + 18'(16'(geom.total) * 16'(cfg.ec_per_block));
    assign bits_full = {bytes, 3'b000} + 21'(cfg.remainder_bits);

    always_comb begin
        valid_res_c = 1'b0;
        kind_c      = KIND_DATA;
        block_c     = '0;
        offset_c    = '0;
        addr_c      = '0;
        last_c      = 1'b0;
        bit_len_c   = '0;
        if (pos.walk.phase != PH_DONE) begin
            valid_res_c = 1'b1;
            last_c      = (nxt.phase == PH_DONE);
            bit_len_c   = bits_full[BIT_LEN_W-1:0];
            if (pos.walk.phase == PH_PAD) begin
                kind_c = KIND_PAD;
            end else begin
                kind_c   = (pos.walk.phase == PH_EC) ? KIND_EC : KIND_DATA;
                block_c  = blk;
                offset_c = col;
                addr_c   = addr_wide[ADDR_BITS-1:0];
            end
        end
    end

    assign take = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= pos.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && pos.valid) begin
            m_valid_res_reg      <= valid_res_c;
            m_kind_reg           <= kind_c;
            m_block_index_reg    <= block_c;
            m_byte_offset_reg    <= offset_c;
            m_source_address_reg <= addr_c;
            m_last_reg           <= last_c;
            m_bit_length_reg     <= bit_len_c;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_valid_res      = m_valid_res_reg;
    assign m_kind           = m_kind_reg;
    assign m_block_index    = m_block_index_reg;
    assign m_byte_offset    = m_byte_offset_reg;
    assign m_source_address = m_source_address_reg;
    assign m_last           = m_last_reg;
    assign m_bit_length     = m_bit_length_reg;

`ifndef SYNTHESIS
    a_pad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg == KIND_PAD) |-> m_last_reg && m_valid_res_reg)
        else $error("pad item not flagged last");

    a_finished_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_valid_res_reg |->
            (m_kind_reg == KIND_DATA) && !m_last_reg && (m_bit_length_reg == '0))
        else $error("finished item carries nonzero fields");

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take && pos.valid |=> m_valid_reg)
        else $error("position lost between stages");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

### rtl/qr_codeword_interleave_sequencer.sv
// ----------------------------------------------------------------------------
// qr_codeword_interleave_sequencer
// Gives the source of each byte of an interleaved codeword stream, one
// position per item: data bytes column by column, ec bytes, then pad if remainder bits are set.
// ----------------------------------------------------------------------------
//  channel   ports                         direction
//  s_        s_valid s_ready s_restart      in
//  m_        m_valid m_ready m_* fields     out
//  cfg_      cfg_valid cfg_ready cfg_index  in (register write)
//
//  one item per cycle sustained while m_ready is high; an accepted item passes
//  the walk register and then the result register; the walk register closes its loop,
//  the result stage adds address multiply and last-flag lookahead
//  synchronous active-low reset, no clearing pass after reset
//  result register decouples the sides: s_ready drops only when both the
//  walk stage and the result register are full and m_ready is low
// ----------------------------------------------------------------------------
`default_nettype none

module qr_codeword_interleave_sequencer
    import qcis_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_restart,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_valid_res,
    output logic [1:0]                 m_kind,
    output logic [7:0]                 m_block_index,
    output logic [7:0]                 m_byte_offset,
    output logic [ADDR_BITS-1:0]       m_source_address,
    output logic                       m_last,
    output logic [BIT_LEN_W-1:0]       m_bit_length,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg;
    stage_t pos;
    logic   take;

    qcis_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qcis_step #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .cfg       (cfg),
        .take      (take),
        .pos       (pos)
    );

    qcis_emit #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .pos              (pos),
        .take             (take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_valid_res      (m_valid_res),
        .m_kind           (m_kind),
        .m_block_index    (m_block_index),
        .m_byte_offset    (m_byte_offset),
        .m_source_address (m_source_address),
        .m_last           (m_last),
        .m_bit_length     (m_bit_length)
    );

endmodule

`default_nettype wire
